>>> hw/rtl/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and constants for the sorted insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int PRI_W     = 16;
	localparam int TAG_W     = 32;
	localparam int OCC_W     = 5;
	localparam int STAT_W    = 2;

	localparam int S_DATA_W  = 48;
	localparam int M_DATA_W  = 40;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_POP    = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                    ins;
		logic                    pop;
		logic signed [PRI_W-1:0] pri;
		logic [TAG_W-1:0]        tag;
	} cell_ctl_t;

endpackage

>>> hw/rtl/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// incoming priority and takes the new entry or a neighbor's entry.
// ----------------------------------------------------------------------------
module sipq_cell (
	input  logic                             clk,
	input  sipq_pkg::cell_ctl_t              ctl,
	input  logic                             occupied,
	input  logic                             left_le,
	input  logic signed [sipq_pkg::PRI_W-1:0] left_pri,
	input  logic [sipq_pkg::TAG_W-1:0]       left_tag,
	input  logic signed [sipq_pkg::PRI_W-1:0] right_pri,
	input  logic [sipq_pkg::TAG_W-1:0]       right_tag,
	output logic                             le,
	output logic signed [sipq_pkg::PRI_W-1:0] pri,
	output logic [sipq_pkg::TAG_W-1:0]       tag
);
	import sipq_pkg::*;

	logic signed [PRI_W-1:0] pri_q;
	logic [TAG_W-1:0]        tag_q;

	// entry stays in place when it sorts at or before the new one
	assign le  = occupied && (pri_q <= ctl.pri);
	assign pri = pri_q;
	assign tag = tag_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !le) begin
			if (left_le) begin
				pri_q <= ctl.pri;
				tag_q <= ctl.tag;
			end else begin
				pri_q <= left_pri;
				tag_q <= left_tag;
			end
		end else if (ctl.pop) begin
			pri_q <= right_pri;
			tag_q <= right_tag;
		end
	end

endmodule

>>> hw/rtl/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded min-priority queue held as a sorted chain of slots; equal
// priorities leave in arrival order.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                 | tuser
//  s_      | in  | item_tag[31:0], entry_priority_in  | req_type
//  m_      | out | popped_tag[31:0], occupancy[4:0]   | status[1:0]
//
// One word per cycle unless the output stalls: every slot compares and shifts
// in the cycle a request is taken, and the result is registered for the next cycle.
// The output register frees itself when taken, so s_tready = !m_tvalid | m_tready.
// Reset clears the entry count and the output valid; slot contents are not reset.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
	parameter int DEPTH = sipq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sipq_pkg::S_DATA_W-1:0]   s_tdata,  // item_tag, entry_priority_in
	input  logic                            s_tuser,  // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sipq_pkg::M_DATA_W-1:0]   m_tdata,  // popped_tag, occupancy, pad
	output logic [sipq_pkg::STAT_W-1:0]     m_tuser   // status
);
	import sipq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]        count_q;
	logic                    m_tvalid_q;
	logic [TAG_W-1:0]        popped_tag_q;
	status_t                 status_q;
	logic [OCC_W-1:0]        occupancy_q;

	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    is_pop;
	cell_ctl_t               ctl;
	logic [CNT_W-1:0]        count_nxt;
	status_t                 status_nxt;
	logic [CNT_W+OCC_W-1:0]  count_ext;

	logic                    le_w  [DEPTH];
	logic signed [PRI_W-1:0] pri_w [DEPTH];
	logic [TAG_W-1:0]        tag_w [DEPTH];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign is_pop   = (s_tuser == REQ_POP);

	always_comb begin
		ctl.ins = accept && !is_pop && !full;
		ctl.pop = accept && is_pop && !empty;
		ctl.tag = s_tdata[TAG_W-1:0];
		ctl.pri = s_tdata[TAG_W+PRI_W-1:TAG_W];

		count_nxt  = count_q;
		status_nxt = ST_OK;
		if (ctl.ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CNT_W'(1);
		end else if (is_pop) begin
			status_nxt = ST_EMPTY;
		end else begin
			status_nxt = ST_FULL;
		end
		count_ext = {{OCC_W{1'b0}}, count_nxt};
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                    left_le;
		logic signed [PRI_W-1:0] left_pri;
		logic [TAG_W-1:0]        left_tag;
		logic signed [PRI_W-1:0] right_pri;
		logic [TAG_W-1:0]        right_tag;

		if (i == 0) begin : g_head
			assign left_le  = 1'b1;
			assign left_pri = ctl.pri;
			assign left_tag = ctl.tag;
		end else begin : g_body
			assign left_le  = le_w[i-1];
			assign left_pri = pri_w[i-1];
			assign left_tag = tag_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_pri = pri_w[i];
			assign right_tag = tag_w[i];
		end else begin : g_mid
			assign right_pri = pri_w[i+1];
			assign right_tag = tag_w[i+1];
		end

		sipq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (CNT_W'(i) < count_q),
			.left_le   (left_le),
			.left_pri  (left_pri),
			.left_tag  (left_tag),
			.right_pri (right_pri),
			.right_tag (right_tag),
			.le        (le_w[i]),
			.pri       (pri_w[i]),
			.tag       (tag_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_tag_q <= ctl.pop ? tag_w[0] : '0;
			status_q     <= status_nxt;
			occupancy_q  <= count_ext[OCC_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-TAG_W-OCC_W){1'b0}}, occupancy_q, popped_tag_q};
	assign m_tuser  = status_q;

endmodule

>>> hw/rtl/sipq_checker.sv
// ----------------------------------------------------------------------------
// sipq_checker
// Port-level checks of the sorted insert priority queue, bound to the top.
// ----------------------------------------------------------------------------
module sipq_checker #(
	parameter int DEPTH = sipq_pkg::DEPTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [sipq_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sipq_pkg::M_DATA_W-1:0] m_tdata,
	input logic [sipq_pkg::STAT_W-1:0]   m_tuser
);
	import sipq_pkg::*;

	localparam logic [OCC_W-1:0] DEPTH_OCC = OCC_W'(DEPTH);

	// empty pop reports nothing removed and nothing held
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |->
			(m_tdata[TAG_W-1:0] == '0) && (m_tdata[TAG_W+OCC_W-1:TAG_W] == '0))
		else $error("empty pop word carries data");

	// dropped insert reports a full queue
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |->
			(m_tdata[TAG_W-1:0] == '0) && (m_tdata[TAG_W+OCC_W-1:TAG_W] == DEPTH_OCC))
		else $error("full drop word wrong");

	// a result word only follows an accepted request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(m_tvalid) && m_tvalid |-> $past(s_tvalid && s_tready))
		else $error("result word without request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result word changed");

	// a waiting request word is held by the sender
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("stalled request word changed");

endmodule

bind sorted_insert_priority_queue sipq_checker #(.DEPTH(DEPTH)) u_sipq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
